>>> hdl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared constants, types and codes of the planar tile blitter.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // Screen and tile geometry.
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 240;
  // The tile count is a power of two, so the wrap of a tile number is a mask.
  localparam int TILE_COUNT    = 512;

  // Table sizes and address widths.
  localparam int PAT_DEPTH    = 8192;
  localparam int PAT_AW       = 13;
  localparam int SLOT_DEPTH   = 32;
  localparam int SLOT_AW      = 5;
  localparam int COLOUR_DEPTH = 64;
  localparam int COLOUR_AW    = 6;

  // Output queue between the draw pipeline and the master port.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  // Highest row or column index inside a tile.
  localparam logic [2:0] TILE_LAST = 3'd7;

  // Input word kinds.
  typedef enum logic [1:0] {
    MODE_PATTERN = 2'd0,
    MODE_SLOT    = 2'd1,
    MODE_COLOUR  = 2'd2,
    MODE_DRAW    = 2'd3
  } mode_t;

  // Draw sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_PIXELS,
    ST_DRAIN
  } draw_state_t;

  // One input word after unpacking.
  typedef struct packed {
    mode_t              mode;
    logic [12:0]        table_address;
    logic [23:0]        write_data;
    logic signed [9:0]  tile_x;
    logic signed [9:0]  tile_y;
    logic               flip_horizontal;
    logic               flip_vertical;
    logic [8:0]         tile_number;
    logic [2:0]         palette_group;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic        pixel_write;
    logic [7:0]  pixel_column;
    logic [7:0]  pixel_row;
    logic [23:0] pixel_rgb;
    logic        last_of_tile;
  } out_item_t;

  // Write request into the output queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

  // Output queue fill level, used for slot reservation.
  typedef struct packed {
    logic [FIFO_AW:0] count;
  } fifo_status_t;

endpackage

>>> hdl/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ptb_fifo.sv
// ----------------------------------------------------------------------------
// ptb_fifo
// Small output queue that decouples the draw pipeline from the master port.
// ----------------------------------------------------------------------------
module ptb_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  ptb_pkg::push_t        push,
  output ptb_pkg::fifo_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ptb_pkg::out_item_t    out_item
);
  import ptb_pkg::*;

  out_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign out_valid    = (count != '0);
  assign pop          = out_valid && out_ready;
  assign out_item     = mem[rd_ptr];
  assign status.count = count;

  // Storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push.valid) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

>>> hdl/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Table memories, draw sequencer and the palette/colour lookup pipeline.
// ----------------------------------------------------------------------------
module ptb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptb_pkg::in_item_t     in_item,
  input  ptb_pkg::fifo_status_t fifo_status,
  output ptb_pkg::push_t        push
);
  import ptb_pkg::*;

  draw_state_t state;
  draw_state_t state_next;

  // Latched draw command.
  logic signed [9:0] x0;
  logic signed [9:0] y0;
  logic              fh;
  logic              fv;
  logic [8:0]        tile;
  logic [2:0]        group;

  // Scan position and the low plane of the current row.
  logic [2:0] ri;
  logic [2:0] cj;
  logic [7:0] lo_byte;

  // Lookup pipeline: palette read in flight, then colour read in flight.
  logic       p1_valid;
  logic [7:0] p1_col;
  logic [7:0] p1_row;
  logic       p2_valid;
  logic [7:0] p2_col;
  logic [7:0] p2_row;

  // The newest pixel is held back until it is known whether it is the last.
  logic      pend_valid;
  out_item_t pend_item;

  // Memory ports.
  logic                 pat_we;
  logic                 pat_re;
  logic [PAT_AW-1:0]    pat_raddr;
  logic [7:0]           pat_rdata;
  logic                 slot_we;
  logic                 slot_re;
  logic [5:0]           slot_rdata;
  logic                 colour_we;
  logic [23:0]          colour_rdata;

  // Combinational controls.
  logic               accept;
  logic               step;
  logic               issue;
  logic               fin;
  logic [FIFO_AW+1:0] used;
  logic               room;
  logic [2:0]         src_row;
  logic [2:0]         src_col;
  logic [2:0]         bit_sel;
  logic signed [10:0] row_s;
  logic signed [10:0] col_s;
  logic               row_vis;
  logic               col_vis;
  logic [1:0]         pix_v;

  assign accept = in_valid && in_ready;

  // Table writes come straight from an accepted word.
  assign pat_we    = accept && (in_item.mode == MODE_PATTERN);
  assign slot_we   = accept && (in_item.mode == MODE_SLOT);
  assign colour_we = accept && (in_item.mode == MODE_COLOUR);

  ptb_ram #(.WIDTH(8), .DEPTH(PAT_DEPTH)) u_pattern (
    .clk   (clk),
    .we    (pat_we),
    .waddr (in_item.table_address[PAT_AW-1:0]),
    .wdata (in_item.write_data[7:0]),
    .re    (pat_re),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  ptb_ram #(.WIDTH(6), .DEPTH(SLOT_DEPTH)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (in_item.table_address[SLOT_AW-1:0]),
    .wdata (in_item.write_data[5:0]),
    .re    (slot_re),
    .raddr ({group, pix_v}),
    .rdata (slot_rdata)
  );

  ptb_ram #(.WIDTH(24), .DEPTH(COLOUR_DEPTH)) u_colours (
    .clk   (clk),
    .we    (colour_we),
    .waddr (in_item.table_address[COLOUR_AW-1:0]),
    .wdata (in_item.write_data),
    .re    (p1_valid),
    .raddr (slot_rdata[COLOUR_AW-1:0]),
    .rdata (colour_rdata)
  );

  // Screen position and value of the pixel under the scan.
  assign src_row = fv ? ~ri : ri;
  assign src_col = fh ? ~cj : cj;
  assign bit_sel = ~cj;
  assign row_s   = {y0[9], y0} + $signed({8'b0, src_row});
  assign col_s   = {x0[9], x0} + $signed({8'b0, src_col});
  assign row_vis = !row_s[10] && (int'(row_s) < SCREEN_HEIGHT);
  assign col_vis = !col_s[10] && (int'(col_s) < SCREEN_WIDTH);
  assign pix_v   = {pat_rdata[bit_sel], lo_byte[bit_sel]};

  // Every issued pixel reserves a queue slot until it is pushed.
  assign used = (FIFO_AW+2)'(fifo_status.count) + (FIFO_AW+2)'(pend_valid)
              + (FIFO_AW+2)'(p1_valid) + (FIFO_AW+2)'(p2_valid);
  assign room = (used < (FIFO_AW+2)'(FIFO_DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_item.mode == MODE_DRAW)) begin
          state_next = ST_FETCH_LO;
        end
      end
      ST_FETCH_LO: state_next = ST_FETCH_HI;
      ST_FETCH_HI: state_next = ST_PIXELS;
      ST_PIXELS: begin
        if (room && (cj == TILE_LAST)) begin
          state_next = (ri == TILE_LAST) ? ST_DRAIN : ST_FETCH_LO;
        end
      end
      ST_DRAIN: begin
        if (fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    pat_re    = 1'b0;
    pat_raddr = {tile, 1'b0, ri};
    step      = 1'b0;
    issue     = 1'b0;
    fin       = 1'b0;
    case (state)
      ST_IDLE:     in_ready = 1'b1;
      ST_FETCH_LO: pat_re = 1'b1;
      ST_FETCH_HI: begin
        pat_re    = 1'b1;
        pat_raddr = {tile, 1'b1, ri};
      end
      ST_PIXELS: begin
        step  = room;
        issue = room && row_vis && col_vis && (pix_v != 2'b00);
      end
      ST_DRAIN: begin
        fin = !p1_valid && !p2_valid
            && (fifo_status.count < (FIFO_AW+1)'(FIFO_DEPTH));
      end
      default: ;
    endcase
  end

  assign slot_re = issue;

  // Push the held pixel when a newer one arrives, and close the draw at the end.
  always_comb begin
    push.valid = (p2_valid && pend_valid) || fin;
    push.item  = pend_item;
    if (fin) begin
      if (pend_valid) begin
        push.item.last_of_tile = 1'b1;
      end else begin
        push.item = '0;
        push.item.last_of_tile = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (fin) begin
        pend_valid <= 1'b0;
      end else if (p2_valid) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Command, scan and pipeline payload registers.
  always_ff @(posedge clk) begin
    if (accept && (in_item.mode == MODE_DRAW)) begin
      x0    <= in_item.tile_x;
      y0    <= in_item.tile_y;
      fh    <= in_item.flip_horizontal;
      fv    <= in_item.flip_vertical;
      tile  <= 9'(in_item.tile_number % TILE_COUNT);
      group <= in_item.palette_group;
      ri    <= '0;
      cj    <= '0;
    end else if (step) begin
      cj <= cj + 1'b1;
      if (cj == TILE_LAST) begin
        ri <= ri + 1'b1;
      end
    end
    if (state == ST_FETCH_HI) begin
      lo_byte <= pat_rdata;
    end
    p1_col <= col_s[7:0];
    p1_row <= row_s[7:0];
    p2_col <= p1_col;
    p2_row <= p1_row;
    if (p2_valid) begin
      pend_item.pixel_write  <= 1'b1;
      pend_item.pixel_column <= p2_col;
      pend_item.pixel_row    <= p2_row;
      pend_item.pixel_rgb    <= colour_rdata;
      pend_item.last_of_tile <= 1'b0;
    end
  end

  // The output queue never takes a word without a free slot.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (fifo_status.count < (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("output queue overflow");

  // A new word is only taken with the lookup pipeline empty.
  a_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!p1_valid && !p2_valid))
    else $error("word accepted while lookups in flight");

  // A word without a pixel write is only ever the closing word.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !push.item.pixel_write) |-> push.item.last_of_tile)
    else $error("empty word not marked last");

  // A colour lookup always follows a palette lookup.
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> $past(p1_valid))
    else $error("colour stage without palette stage");

endmodule

>>> hdl/planar_tile_blitter.sv
// ----------------------------------------------------------------------------
// planar_tile_blitter
// Two-bitplane 8x8 tile renderer with pattern, palette and colour tables.
// ----------------------------------------------------------------------------
// Table writes (kinds 0, 1 and 2) are taken while idle and give no output
// word. A draw (kind 3) walks the tile one source row at a time: the
// FETCH_LO and FETCH_HI states read the low and high plane bytes from the
// single read port of the pattern memory, then the columns are scanned at
// one per cycle while the output queue has room. The input is not ready
// again until a draw has ended and its last word has been queued.
// Each visible opaque pixel passes through a palette lookup and a colour
// lookup into an eight-word output queue; when no slot is free, counting
// those reserved by lookups in flight, the column scan waits. Every draw
// ends with a word carrying tlast, which is an empty word (tuser low, data
// zero) when no pixel was written. The tables are not cleared at reset and
// must be written before they are used.
// ----------------------------------------------------------------------------
module planar_tile_blitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] table_address, [36:13] write_data, [46:37] tile_x, [56:47] tile_y,
  // [57] flip_horizontal, [58] flip_vertical, [67:59] tile_number,
  // [70:68] palette_group, [71] zero
  input  logic [71:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_column, [15:8] pixel_row, [39:16] pixel_rgb
  output logic [39:0] m_axis_tdata,
  // [0] pixel_write
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import ptb_pkg::*;

  in_item_t     in_item;
  push_t        push;
  fifo_status_t fifo_status;
  out_item_t    out_item;

  // Unpack the slave word.
  assign in_item.mode            = mode_t'(s_axis_tuser);
  assign in_item.table_address   = s_axis_tdata[12:0];
  assign in_item.write_data      = s_axis_tdata[36:13];
  assign in_item.tile_x          = s_axis_tdata[46:37];
  assign in_item.tile_y          = s_axis_tdata[56:47];
  assign in_item.flip_horizontal = s_axis_tdata[57];
  assign in_item.flip_vertical   = s_axis_tdata[58];
  assign in_item.tile_number     = s_axis_tdata[67:59];
  assign in_item.palette_group   = s_axis_tdata[70:68];

  ptb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .fifo_status (fifo_status),
    .push        (push)
  );

  ptb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .status    (fifo_status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  // Pack the master word.
  assign m_axis_tdata = {out_item.pixel_rgb, out_item.pixel_row, out_item.pixel_column};
  assign m_axis_tuser = out_item.pixel_write;
  assign m_axis_tlast = out_item.last_of_tile;

endmodule
